[hw/rtl/askw_pkg.sv]
`default_nettype none
package askw_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CfgKekLow   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgKekHigh  = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgSaltLow  = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgSaltHigh = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgIter     = 3'd4;
    localparam logic [63:0] WrapIv = 64'hA6A6_A6A6_A6A6_A6A6;
    localparam logic CmdWrap = 1'b0;
    localparam logic CmdUnwrap = 1'b1;

    typedef struct packed {
        logic       start;
        logic       dec;
        logic       key_load;
    } t_aes_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    // inverse substitution table
    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

[hw/rtl/askw_if.sv]
`default_nettype none
interface askw_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] block_a;
    logic [63:0] key_low;
    logic [63:0] key_high;
    modport source (output valid, cmd, block_a, key_low, key_high, input ready);
    modport sink (input valid, cmd, block_a, key_low, key_high, output ready);
endinterface

interface askw_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_a;
    logic [63:0] out_low;
    logic [63:0] out_high;
    logic        integrity_ok;
    modport source (output valid, out_a, out_low, out_high, integrity_ok, input ready);
    modport sink (input valid, out_a, out_low, out_high, integrity_ok, output ready);
endinterface

interface askw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/askw_ram.sv]
`default_nettype none
module askw_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/askw_core.sv]
`default_nettype none
// one aes round per cycle; round keys read from a 16-entry x 128-bit ram
module askw_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire askw_pkg::t_aes_ctl  i_ctl,
    input  wire logic [127:0]        i_kek,
    input  wire logic [127:0]        i_blk,
    output logic                     o_done,
    output logic [127:0]             o_blk
);
    typedef enum logic [1:0] {S_IDLE, S_KEY, S_RUN} t_state;
    t_state       r_state;
    logic [3:0]   r_rnd;
    logic         r_dec;
    logic [127:0] r_key;
    logic [127:0] r_s;
    logic         r_first;
    logic [127:0] rk;
    logic [3:0]   raddr;
    logic [3:0]   kaddr;
    logic         kwe;
    logic [127:0] nkey;
    logic [31:0]  w3, tw;
    logic [127:0] enc_s, dec_s, sh, sb;
    logic [7:0]   bt [16];
    logic [7:0]   ub [16];
    logic [7:0]   mb [16];

    askw_ram #(.Width(128), .Depth(16)) u_rk (
        .i_clk, .i_we(kwe), .i_waddr(kaddr), .i_wdata(r_key),
        .i_raddr(raddr), .o_rdata(rk)
    );

    // next key: byte 0 of the block sits in bits 127:120
    always_comb begin
        w3 = r_key[31:0];
        tw = {askw_pkg::sbox(w3[23:16]), askw_pkg::sbox(w3[15:8]),
              askw_pkg::sbox(w3[7:0]), askw_pkg::sbox(w3[31:24])}
             ^ {askw_pkg::rcon(r_rnd + 4'd1), 24'd0};
        nkey[127:96] = r_key[127:96] ^ tw;
        nkey[95:64]  = r_key[95:64] ^ nkey[127:96];
        nkey[63:32]  = r_key[63:32] ^ nkey[95:64];
        nkey[31:0]   = r_key[31:0] ^ nkey[63:32];
    end

    assign kwe = (r_state == S_KEY);
    assign kaddr = r_rnd;

    // read address runs one ahead of the round in use; during the whitening
    // cycle that is round one, afterwards the round after r_rnd + 1
    always_comb begin
        if (r_state == S_RUN) begin
            raddr = r_dec ? 4'd10 - r_rnd - (r_first ? 4'd1 : 4'd2)
                          : r_rnd + (r_first ? 4'd1 : 4'd2);
        end else begin
            raddr = i_ctl.dec ? 4'd10 : 4'd0;
        end
    end

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            bt[k] = r_s[127-8*k -: 8];
        end
        // encrypt round: sbox, shift rows, mix columns (skipped in the last round), round key
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                ub[i+4*c] = askw_pkg::sbox(bt[i + 4*((c+i)%4)]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] x;
            x = ub[4*c] ^ ub[4*c+1] ^ ub[4*c+2] ^ ub[4*c+3];
            for (int i = 0; i < 4; i++) begin
                mb[4*c+i] = (r_rnd == 4'd9) ? ub[4*c+i] :
                    ub[4*c+i] ^ x ^ askw_pkg::xt(ub[4*c+i] ^ ub[4*c+((i+1)%4)]);
            end
        end
        for (int k = 0; k < 16; k++) begin
            enc_s[127-8*k -: 8] = mb[k];
        end
        enc_s = enc_s ^ rk;
        // decrypt round: inv shift, inv sbox, key, inv mix (skipped in the last round)
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sh[127-8*(i + 4*((c+i)%4)) -: 8] = bt[i+4*c];
            end
        end
        for (int k = 0; k < 16; k++) begin
            sb[127-8*k -: 8] = askw_pkg::inv_sbox(sh[127-8*k -: 8]);
        end
        sb = sb ^ rk;
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a [4];
            logic [7:0] a2 [4];
            logic [7:0] a4 [4];
            logic [7:0] a8 [4];
            for (int i = 0; i < 4; i++) begin
                a[i] = sb[127-8*(4*c+i) -: 8];
                a2[i] = askw_pkg::xt(a[i]);
                a4[i] = askw_pkg::xt(a2[i]);
                a8[i] = askw_pkg::xt(a4[i]);
            end
            for (int i = 0; i < 4; i++) begin
                dec_s[127-8*(4*c+i) -: 8] = (r_rnd == 4'd9) ? a[i] :
                    (a8[i] ^ a4[i] ^ a2[i])
                    ^ (a8[(i+1)%4] ^ a2[(i+1)%4] ^ a[(i+1)%4])
                    ^ (a8[(i+2)%4] ^ a4[(i+2)%4] ^ a[(i+2)%4])
                    ^ (a8[(i+3)%4] ^ a[(i+3)%4]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
            o_done  <= 1'b0;
            r_dec   <= 1'b0;
            r_first <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.key_load) begin
                        r_key   <= i_kek;
                        r_rnd   <= '0;
                        r_state <= S_KEY;
                    end else if (i_ctl.start) begin
                        r_dec   <= i_ctl.dec;
                        r_s     <= i_blk;
                        r_first <= 1'b1;
                        r_rnd   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_KEY: begin
                    r_key <= nkey;
                    r_rnd <= r_rnd + 4'd1;
                    if (r_rnd == 4'd10) begin
                        r_state <= S_IDLE;
                        o_done  <= 1'b1;
                    end
                end
                S_RUN: begin
                    if (r_first) begin
                        // whitening key was read last cycle
                        r_s     <= r_s ^ rk;
                        r_first <= 1'b0;
                    end else begin
                        r_s   <= r_dec ? dec_s : enc_s;
                        r_rnd <= r_rnd + 4'd1;
                        if (r_rnd == 4'd9) begin
                            r_state <= S_IDLE;
                            o_done  <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_blk = r_s;
endmodule
`default_nettype wire

[hw/rtl/aes128_salted_iterated_key_wrap.sv]
`default_nettype none
// salted, iterated aes-128 key wrap of one 128-bit key
// channels: in_ch takes one item (cmd, block_a, key_low, key_high); out_ch
// gives one item (out_a, out_low, out_high, integrity_ok) per input item.
// cfg_ch writes kek_low, kek_high, salt_low, salt_high, iterations by index
// 0..4; other indexes are dropped. write config only while idle.
// per item: key expansion from accept (a handoff, eleven round keys into the
// ram, done seen), then iterations x 2 aes blocks (start, whitening, ten rounds,
// done), then the result moves into the output register.
// the next item can be taken in the cycle after the result is registered;
// items are taken one at a time; the single aes round unit serves them in turn.
// in_ch.ready is high only while the sequencer is idle.
// a stalled receiver leaves the result in the output register while the
// next item is processed; that item then waits until the register frees.
// reset clears the registers to kek=salt=0, six iterations, and returns to
// idle with no result pending.
module aes128_salted_iterated_key_wrap (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    askw_in_if.sink        in_ch,
    askw_out_if.source     out_ch,
    askw_cfg_if.sink       cfg_ch
);
    typedef enum logic [2:0] {S_IDLE, S_KEY, S_BLK, S_WAIT, S_OUT} t_state;
    t_state       r_state;
    logic [63:0]  r_kek_lo, r_kek_hi, r_salt_lo, r_salt_hi;
    logic [31:0]  r_iter;
    logic         r_dec;
    logic [63:0]  r_a;
    logic [63:0]  r_r [2];
    logic [31:0]  r_j;      // outer rounds still to go
    logic         r_i;      // 0 -> word 1, 1 -> word 2
    logic [63:0]  r_t;      // running t value
    logic         r_ov;     // output register holds an item
    logic [63:0]  r_oa, r_olo, r_ohi;
    logic         r_ook;
    logic         load_out;
    askw_pkg::t_aes_ctl ctl;
    logic         done;
    logic [127:0] blk_in, blk_out;
    logic [63:0]  a_in, oa, orw;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kek_lo  <= '0;
            r_kek_hi  <= '0;
            r_salt_lo <= '0;
            r_salt_hi <= '0;
            r_iter    <= 32'd6;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                askw_pkg::CfgKekLow:   r_kek_lo  <= cfg_ch.data;
                askw_pkg::CfgKekHigh:  r_kek_hi  <= cfg_ch.data;
                askw_pkg::CfgSaltLow:  r_salt_lo <= cfg_ch.data;
                askw_pkg::CfgSaltHigh: r_salt_hi <= cfg_ch.data;
                askw_pkg::CfgIter:     r_iter    <= cfg_ch.data[31:0];
                default: ;
            endcase
        end
    end

    // bytes little-endian in words, big-endian in the aes block vector
    function automatic logic [63:0] bswap(input logic [63:0] w);
        logic [63:0] v;
        for (int k = 0; k < 8; k++) begin
            v[63-8*k -: 8] = w[8*k +: 8];
        end
        return v;
    endfunction

    logic [127:0] kek;
    assign kek = {bswap(r_kek_lo ^ r_salt_lo), bswap(r_kek_hi ^ r_salt_hi)};
    assign a_in = r_dec ? (r_a ^ r_t) : r_a;
    assign blk_in = {bswap(a_in), bswap(r_r[r_i])};
    assign oa = bswap(blk_out[127:64]);
    assign orw = bswap(blk_out[63:0]);

    always_comb begin
        ctl.key_load = (r_state == S_KEY);
        ctl.start    = (r_state == S_BLK);
        ctl.dec      = r_dec;
    end

    askw_core u_core (
        .i_clk, .i_rst_n, .i_ctl(ctl), .i_kek(kek), .i_blk(blk_in),
        .o_done(done), .o_blk(blk_out)
    );

    // finished result moves out once the output register is free or being taken
    assign load_out = (r_state == S_OUT) && (!r_ov || out_ch.ready);

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_ov;
    assign out_ch.out_a = r_oa;
    assign out_ch.out_low = r_olo;
    assign out_ch.out_high = r_ohi;
    assign out_ch.integrity_ok = r_ook;

    logic r_keyed;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_keyed <= 1'b0;
            r_dec   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (load_out) begin
                r_ov  <= 1'b1;
                r_oa  <= r_a;
                r_olo <= r_r[0];
                r_ohi <= r_r[1];
                r_ook <= r_dec ? (r_a == askw_pkg::WrapIv) : 1'b1;
            end else if (out_ch.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_dec   <= in_ch.cmd;
                        r_a     <= (in_ch.cmd == askw_pkg::CmdUnwrap) ? in_ch.block_a
                                                                      : askw_pkg::WrapIv;
                        r_r[0]  <= in_ch.key_low;
                        r_r[1]  <= in_ch.key_high;
                        r_j     <= r_iter;
                        r_i     <= (in_ch.cmd == askw_pkg::CmdUnwrap);
                        r_t     <= (in_ch.cmd == askw_pkg::CmdUnwrap)
                                   ? 64'({r_iter, 1'b0}) : 64'd1;
                        r_keyed <= 1'b0;
                        r_state <= S_KEY;
                    end
                end
                S_KEY: begin
                    r_state <= S_WAIT;
                end
                S_BLK: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!r_keyed) begin
                        if (done) begin
                            r_keyed <= 1'b1;
                            r_state <= (r_j == '0) ? S_OUT : S_BLK;
                        end
                    end else if (done) begin
                        r_r[r_i] <= orw;
                        r_a      <= r_dec ? oa : (oa ^ r_t);
                        r_t      <= r_dec ? r_t - 64'd1 : r_t + 64'd1;
                        r_i      <= ~r_i;
                        // word 2 closes a wrap round, word 1 an unwrap round
                        if (r_i != r_dec) begin
                            r_j <= r_j - 32'd1;
                            r_state <= (r_j == 32'd1) ? S_OUT : S_BLK;
                        end else begin
                            r_state <= S_BLK;
                        end
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_noacc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(r_oa)))
        else $error("result dropped");
    a_wrap_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && !r_dec) |=> out_ch.integrity_ok) else $error("wrap flag");
    a_start_keyed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLK) |-> r_keyed) else $error("block before key");
endmodule
`default_nettype wire
